// ----- design/brbx_pkg.sv -----
// Shared widths, register indexes, reset values and types for the box exit distance block.
`timescale 1ns / 1ps

package brbx_pkg;

  // Widths fixed by the field formats
  localparam int COORD_BITS_DEF = 16;
  localparam int DIR_W          = 16;
  localparam int DIST_W         = 16;
  localparam int LIMIT_W        = 15;
  localparam int MAG_W          = 15;
  localparam int DSQ_W          = 31;
  localparam int SUM_W          = 32;
  localparam int MSQ_W          = 2 * MAG_W;
  localparam int SQ_W           = 62;
  localparam int ROOT_W         = SQ_W / 2;
  localparam int DEN_W          = 16;
  localparam int QUO_W          = 17;
  localparam int DIV_LAT        = QUO_W + 1;
  localparam int NUM_AXES       = 3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_LIMIT   = 3'd6;

  // Reset values
  localparam int RST_BOX_X_MIN = 0;
  localparam int RST_BOX_X_MAX = 4102;
  localparam int RST_BOX_Y_MIN = -1864;
  localparam int RST_BOX_Y_MAX = 1864;
  localparam int RST_BOX_Z_MIN = 0;
  localparam int RST_BOX_Z_MAX = 16589;
  localparam logic [LIMIT_W-1:0] RST_DIST_LIMIT = 15'd3198;

  // Saturation points of an axis quotient
  localparam logic [QUO_W-1:0] QUO_SAT = 17'd32768;
  localparam logic [QUO_W-1:0] POS_MAX = 17'd32767;

  typedef struct packed {
    logic             skip;  // direction component is zero
    logic             big;   // gap magnitude at least 2^15
    logic             neg;   // gap is negative
    logic [DEN_W-1:0] den;   // magnitude of the direction component
  } brbx_axis_t;

  typedef struct packed {
    brbx_axis_t [NUM_AXES-1:0] ax;
    logic                      zero;
  } brbx_side_t;

endpackage

// ----- design/backward_ray_box_exit_distance.sv -----
// Top level: configuration registers, axis lanes, side line, minimum and output buffer.
`timescale 1ns / 1ps

// Backward ray to box wall exit distance. One ray word is taken per clock while the
// output buffer has room, and one result word leaves per ray, in order, through
// three front stages (gap, squares, radicand), a 31-stage square-root pipe and an
// 18-stage divider per axis, and a two-entry output buffer. The three axes run in
// parallel lanes, so the rate is one ray per cycle; the input stalls only once both
// output buffer entries are full. Box walls and the distance limit are
// written through cfg_we_i and must only change while no ray is in flight.
module backward_ray_box_exit_distance #(
  parameter int COORD_BITS = brbx_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [brbx_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [((COORD_BITS > brbx_pkg::LIMIT_W) ? COORD_BITS : brbx_pkg::LIMIT_W)-1:0]
                                            cfg_data_i,
  // ray stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z (lowest first), zero padded
  input  logic [((3*COORD_BITS + 3*brbx_pkg::DIR_W + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // wall_distance
  output logic [brbx_pkg::DIST_W-1:0]       m_axis_tdata_o,
  // zero_direction
  output logic [0:0]                        m_axis_tuser_o
);
  import brbx_pkg::*;

  localparam int LAT = ROOT_W + DIV_LAT;

  typedef struct packed {
    logic              zero;
    logic [DIST_W-1:0] wall_dist;
  } brbx_res_t;

  logic [NUM_AXES-1:0][COORD_BITS-1:0] box_lo_q, box_hi_q;
  logic [LIMIT_W-1:0]                  limit_q;

  logic                                en;
  logic [NUM_AXES-1:0][COORD_BITS-1:0] start;
  logic [NUM_AXES-1:0][DIR_W-1:0]      dir;
  logic                                front_vld;
  brbx_side_t                          front_side;
  logic [NUM_AXES-1:0][SQ_W-1:0]       front_x;
  logic [NUM_AXES-1:0][ROOT_W-1:0]     root;
  logic [NUM_AXES-1:0][QUO_W-1:0]      quo;
  logic [NUM_AXES-1:0]                 ovf;

  brbx_side_t     side_q [LAT];
  logic [LAT-1:0] vld_q;

  brbx_res_t      res_d;
  brbx_res_t      buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_lo_q[0] <= COORD_BITS'(RST_BOX_X_MIN);
      box_hi_q[0] <= COORD_BITS'(RST_BOX_X_MAX);
      box_lo_q[1] <= COORD_BITS'(RST_BOX_Y_MIN);
      box_hi_q[1] <= COORD_BITS'(RST_BOX_Y_MAX);
      box_lo_q[2] <= COORD_BITS'(RST_BOX_Z_MIN);
      box_hi_q[2] <= COORD_BITS'(RST_BOX_Z_MAX);
      limit_q     <= RST_DIST_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOX_X_MIN:  box_lo_q[0] <= cfg_data_i[COORD_BITS-1:0];
        REG_BOX_X_MAX:  box_hi_q[0] <= cfg_data_i[COORD_BITS-1:0];
        REG_BOX_Y_MIN:  box_lo_q[1] <= cfg_data_i[COORD_BITS-1:0];
        REG_BOX_Y_MAX:  box_hi_q[1] <= cfg_data_i[COORD_BITS-1:0];
        REG_BOX_Z_MIN:  box_lo_q[2] <= cfg_data_i[COORD_BITS-1:0];
        REG_BOX_Z_MAX:  box_hi_q[2] <= cfg_data_i[COORD_BITS-1:0];
        REG_DIST_LIMIT: limit_q     <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole pipe advances while the output buffer has room or is draining
  assign pop             = m_axis_tvalid_o & m_axis_tready_i;
  assign en              = (cnt_q != 2'd2) | pop;
  assign s_axis_tready_o = en;

  // Unpack the ray word
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_unpack
    assign start[k] = s_axis_tdata_i[k*COORD_BITS +: COORD_BITS];
    assign dir[k]   = s_axis_tdata_i[NUM_AXES*COORD_BITS + k*DIR_W +: DIR_W];
  end

  brbx_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .start_i (start),
    .lo_i    (box_lo_q),
    .hi_i    (box_hi_q),
    .dir_i   (dir),
    .valid_o (front_vld),
    .side_o  (front_side),
    .x_o     (front_x)
  );

  // Side line: flags and divisors ride alongside the root and divider pipes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], front_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= front_side;
      for (int i = 1; i < LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // One root and divider lane per axis
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
    brbx_isqrt u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (front_x[k]),
      .root_o (root[k])
    );

    brbx_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .r_i   (root[k]),
      .den_i (side_q[ROOT_W-1].ax[k].den),
      .quo_o (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  // Saturate each axis, take the minimum against the limit
  always_comb begin
    logic [QUO_W-1:0]        mag;
    logic signed [QUO_W-1:0] ti, t;
    brbx_axis_t              ax;
    t = $signed({2'b00, limit_q});
    for (int k = 0; k < NUM_AXES; k++) begin
      ax  = side_q[LAT-1].ax[k];
      mag = (ax.big | ovf[k] | (quo[k] > QUO_SAT)) ? QUO_SAT : quo[k];
      ti  = ax.neg ? $signed(QUO_W'(-mag)) : $signed((mag > POS_MAX) ? POS_MAX : mag);
      if (!ax.skip && (ti < t)) begin
        t = ti;
      end
    end
    res_d.zero      = side_q[LAT-1].zero;
    res_d.wall_dist = side_q[LAT-1].zero ? {1'b0, limit_q} : t[DIST_W-1:0];
  end

  // Two-entry output buffer
  assign push = en & vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res_d;
    end
  end

  assign m_axis_tvalid_o   = (cnt_q != 2'd0);
  assign m_axis_tdata_o    = buf_q[rd_ptr_q].wall_dist;
  assign m_axis_tuser_o[0] = buf_q[rd_ptr_q].zero;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (cnt_q == 2'd2 && !m_axis_tready_i))
    else $error("input stalled with room in the output buffer");

  a_zero_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == {1'b0, limit_q}))
    else $error("zero direction result differs from the limit");

  a_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o) <= $signed({1'b0, limit_q})))
    else $error("distance above the limit");

endmodule

// ----- design/brbx_front.sv -----
// Front stages: gaps, component squares, squared length and the radicand per axis.
`timescale 1ns / 1ps

module brbx_front #(
  parameter int COORD_BITS = brbx_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [brbx_pkg::NUM_AXES-1:0][COORD_BITS-1:0] start_i,
  input  logic [brbx_pkg::NUM_AXES-1:0][COORD_BITS-1:0] lo_i,
  input  logic [brbx_pkg::NUM_AXES-1:0][COORD_BITS-1:0] hi_i,
  input  logic [brbx_pkg::NUM_AXES-1:0][brbx_pkg::DIR_W-1:0] dir_i,
  output logic                                          valid_o,
  output brbx_pkg::brbx_side_t                          side_o,
  output logic [brbx_pkg::NUM_AXES-1:0][brbx_pkg::SQ_W-1:0] x_o
);
  import brbx_pkg::*;

  localparam int GW = (COORD_BITS + 1 > 16) ? COORD_BITS + 1 : 16;

  brbx_side_t                    side_a_d, side_a_q, side_b_q, side_c_q;
  logic [NUM_AXES-1:0][MAG_W-1:0] mag_a_d, mag_a_q;
  logic [NUM_AXES-1:0][DSQ_W-1:0] dsq_a_d, dsq_a_q;
  logic [SUM_W-1:0]               sum_b_d, sum_b_q;
  logic [NUM_AXES-1:0][MSQ_W-1:0] msq_b_d, msq_b_q;
  logic [NUM_AXES-1:0][SQ_W-1:0]  x_c_d, x_c_q;
  logic                           vld_a_q, vld_b_q, vld_c_q;

  // Stage A: pick the wall the backward ray heads for and square the component
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_ax
    logic signed [GW-1:0]      s_w, lo_w, hi_w, gap;
    logic [GW-1:0]             mag_abs;
    logic signed [2*DIR_W-1:0] prod;

    assign s_w     = GW'($signed(start_i[k]));
    assign lo_w    = GW'($signed(lo_i[k]));
    assign hi_w    = GW'($signed(hi_i[k]));
    assign gap     = dir_i[k][DIR_W-1] ? (hi_w - s_w) : (s_w - lo_w);
    assign mag_abs = gap[GW-1] ? GW'(-gap) : GW'(gap);
    assign prod    = $signed(dir_i[k]) * $signed(dir_i[k]);

    assign side_a_d.ax[k].skip = (dir_i[k] == '0);
    assign side_a_d.ax[k].big  = |mag_abs[GW-1:MAG_W];
    assign side_a_d.ax[k].neg  = gap[GW-1];
    assign side_a_d.ax[k].den  = dir_i[k][DIR_W-1] ? DEN_W'(-dir_i[k]) : dir_i[k];
    assign mag_a_d[k]          = mag_abs[MAG_W-1:0];
    assign dsq_a_d[k]          = prod[DSQ_W-1:0];

    // Stage B: square the gap; stage C: form the radicand
    assign msq_b_d[k] = {{MAG_W{1'b0}}, mag_a_q[k]} * {{MAG_W{1'b0}}, mag_a_q[k]};
    assign x_c_d[k]   = {{(SQ_W-MSQ_W){1'b0}}, msq_b_q[k]} *
                        {{(SQ_W-SUM_W){1'b0}}, sum_b_q};
  end

  assign side_a_d.zero = side_a_d.ax[0].skip & side_a_d.ax[1].skip & side_a_d.ax[2].skip;

  // Sum the squared components
  assign sum_b_d = {1'b0, dsq_a_q[0]} + {1'b0, dsq_a_q[1]} + {1'b0, dsq_a_q[2]};

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  // Advance the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_a_q <= side_a_d;
      mag_a_q  <= mag_a_d;
      dsq_a_q  <= dsq_a_d;
      side_b_q <= side_a_q;
      sum_b_q  <= sum_b_d;
      msq_b_q  <= msq_b_d;
      side_c_q <= side_b_q;
      x_c_q    <= x_c_d;
    end
  end

  assign valid_o = vld_c_q;
  assign side_o  = side_c_q;
  assign x_o     = x_c_q;

endmodule

// ----- design/brbx_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module brbx_isqrt (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [brbx_pkg::SQ_W-1:0]   x_i,
  output logic [brbx_pkg::ROOT_W-1:0] root_o
);
  import brbx_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic [REM_W-1:0]  rem_q  [ROOT_W-1];
  logic [SQ_W-1:0]   x_q    [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic [REM_W-1:0]  rem_in, cur, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   x_in;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    assign cur   = {rem_in[REM_W-3:0], x_in[SQ_W-1-2*k -: 2]};
    assign trial = REM_W'({root_in, 2'b01});
    assign take  = (cur >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[ROOT_W-2:0], take};
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? (cur - trial) : cur;
          x_q[k]   <= x_in;
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ----- design/brbx_div.sv -----
// Pipelined restoring divider with an overflow check ahead of the quotient stages.
`timescale 1ns / 1ps

module brbx_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [brbx_pkg::ROOT_W-1:0] r_i,
  input  logic [brbx_pkg::DEN_W-1:0]  den_i,
  output logic [brbx_pkg::QUO_W-1:0]  quo_o,
  output logic                        ovf_o
);
  import brbx_pkg::*;

  localparam int SH_W  = ROOT_W + 1;
  localparam int CMP_W = DEN_W + QUO_W;

  logic [ROOT_W-1:0] rem0_q;
  logic [DEN_W-1:0]  den0_q;
  logic              ovf0_q;
  logic [ROOT_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0]  den_q [QUO_W-1];
  logic [QUO_W-1:0]  quo_q [QUO_W];
  logic              ovf_q [QUO_W];

  // Flag quotients of 2^17 and above, then hold the operands
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf0_q <= (CMP_W'(r_i) >= {den_i, {QUO_W{1'b0}}});
      rem0_q <= r_i;
      den0_q <= den_i;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_st
    localparam int B = QUO_W - 1 - k;
    logic [ROOT_W-1:0] rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  quo_in, quo_d;
    logic              ovf_in, take;
    logic [SH_W-1:0]   sh;

    if (k == 0) begin : g_first
      assign rem_in = rem0_q;
      assign den_in = den0_q;
      assign quo_in = '0;
      assign ovf_in = ovf0_q;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign ovf_in = ovf_q[k-1];
    end

    // Try the shifted divisor against the partial remainder
    assign sh   = SH_W'({{(SH_W-DEN_W){1'b0}}, den_in} << B);
    assign take = ({1'b0, rem_in} >= sh);

    always_comb begin
      quo_d    = quo_in;
      quo_d[B] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= quo_d;
        ovf_q[k] <= ovf_in;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? ROOT_W'({1'b0, rem_in} - sh) : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];
  assign ovf_o = ovf_q[QUO_W-1];

endmodule
